// ===== src/dfe_pkg.sv =====
package dfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int DELIM_LEN   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SECOND  = 8'd3;

    localparam logic [BYTE_W-1:0] RST_START_FIRST  = 8'h07;
    localparam logic [BYTE_W-1:0] RST_START_SECOND = 8'hF0;
    localparam logic [BYTE_W-1:0] RST_STOP_FIRST   = 8'h07;
    localparam logic [BYTE_W-1:0] RST_STOP_SECOND  = 8'h0F;

    // per-cell control: load a new byte, or take the upper neighbor's byte
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== src/dfe_cell.sv =====
module dfe_cell
(
    input  logic                      clk,
    input  dfe_pkg::cell_ctl_t        ctl,
    input  logic [dfe_pkg::BYTE_W-1:0] load_data,
    input  logic [dfe_pkg::BYTE_W-1:0] shift_in,
    output logic [dfe_pkg::BYTE_W-1:0] q
);

    logic [dfe_pkg::BYTE_W-1:0] byte_reg;
    logic [dfe_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            byte_next = load_data;
        end
        else if (ctl.shift)
        begin
            byte_next = shift_in;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

// ===== src/delimited_frame_extractor_core.sv =====
// Delimited frame extractor.
// s_* : input byte stream, one byte per beat in s_tdata.
// m_* : frame output, one beat per frame byte, start delimiter first;
//       m_tdata holds the byte and its position in the frame, m_tlast marks
//       the final stop delimiter byte.
// cfg_* : register writes (start/stop delimiter bytes), always ready.
// While hunting or buffering, a byte is taken every cycle. The byte that
// completes the stop pair starts emission of the whole frame: it sets the emit
// flag, and the output register then loads from cell 0, one beat per cycle
// unless the receiver stalls, with the cell row shifting one byte toward cell 0
// per beat. The input is held off during emission and is ready again in the
// cycle after the last beat is loaded into the output register.
// A receiver stall (m_tready low) holds the output beat and freezes the row.
// Frames that would exceed MAX_FRAME bytes are dropped silently.
// Reset: hunting, no frame buffered, delimiter registers at their defaults;
// there is no clearing pass, input is accepted as soon as reset is released.
module delimited_frame_extractor_core
#(
    parameter int MAX_FRAME = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] frame_byte, [13:8] byte_position, [15:14] 0
    output logic        m_tlast,     // last_in_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int BW    = dfe_pkg::BYTE_W;

    logic [BW-1:0] start_first_reg, start_second_reg, stop_first_reg, stop_second_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             inside_reg, inside_next;
    logic [BW-1:0]    prev_reg, prev_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             emit_reg, emit_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    logic             out_valid_reg, out_valid_next;
    logic [BW-1:0]    out_byte_reg, out_byte_next;
    logic [dfe_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic             out_last_reg, out_last_next;

    logic [BW-1:0] cell_q [MAX_FRAME];
    dfe_pkg::cell_ctl_t cell_ctl [MAX_FRAME];
    logic [BW-1:0] cell_ld [MAX_FRAME];

    logic in_acc, out_free, step, step_last;
    logic hunt, start_hit, append, stop_hit, overflow;
    logic [BW-1:0] b;

    assign b        = s_tdata;
    assign s_tready = !emit_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign step     = emit_reg && out_free;
    assign step_last = (CNT_W'(pos_reg + 1'b1) == len_reg);

    assign overflow  = inside_reg && (count_reg == CNT_W'(MAX_FRAME));
    assign hunt      = in_acc && (!inside_reg || overflow);
    assign start_hit = hunt && prev_valid_reg && (prev_reg == start_first_reg)
                       && (b == start_second_reg);
    assign append    = in_acc && inside_reg && !overflow;
    assign stop_hit  = append && prev_valid_reg && (prev_reg == stop_first_reg)
                       && (b == stop_second_reg);

    always_comb
    begin
        count_next      = count_reg;
        inside_next     = inside_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        emit_next       = emit_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        if (hunt)
        begin
            if (start_hit)
            begin
                count_next      = CNT_W'(dfe_pkg::DELIM_LEN);
                inside_next     = 1'b1;
                prev_valid_next = 1'b0;
            end
            else
            begin
                count_next      = '0;
                inside_next     = 1'b0;
                prev_next       = b;
                prev_valid_next = 1'b1;
            end
        end
        else if (append)
        begin
            if (stop_hit)
            begin
                emit_next       = 1'b1;
                len_next        = CNT_W'(count_reg + 1'b1);
                pos_next        = '0;
                inside_next     = 1'b0;
                count_next      = '0;
                prev_valid_next = 1'b0;
            end
            else
            begin
                count_next      = CNT_W'(count_reg + 1'b1);
                prev_next       = b;
                prev_valid_next = 1'b1;
            end
        end
        if (step)
        begin
            pos_next = CNT_W'(pos_reg + 1'b1);
            if (step_last)
            begin
                emit_next = 1'b0;
            end
        end
    end

    // output register: reloads from cell 0 on each emission step
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cell_q[0];
            out_pos_next   = dfe_pkg::POS_W'(pos_reg);
            out_last_next  = step_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAME; gi++)
        begin : g_cell
            logic [BW-1:0] up;
            if (gi == MAX_FRAME - 1)
            begin : g_top
                assign up = cell_q[gi];
            end
            else
            begin : g_mid
                assign up = cell_q[gi+1];
            end

            always_comb
            begin
                cell_ctl[gi].shift = step;
                cell_ctl[gi].load  = append && (count_reg == CNT_W'(gi));
                cell_ld[gi]        = b;
                if (gi == 0)
                begin
                    cell_ctl[gi].load = cell_ctl[gi].load || start_hit;
                    if (start_hit)
                    begin
                        cell_ld[gi] = start_first_reg;
                    end
                end
                else if (gi == 1)
                begin
                    cell_ctl[gi].load = cell_ctl[gi].load || start_hit;
                    if (start_hit)
                    begin
                        cell_ld[gi] = start_second_reg;
                    end
                end
            end

            dfe_cell u_cell
            (
                .clk       (clk),
                .ctl       (cell_ctl[gi]),
                .load_data (cell_ld[gi]),
                .shift_in  (up),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= dfe_pkg::RST_START_FIRST;
            start_second_reg <= dfe_pkg::RST_START_SECOND;
            stop_first_reg   <= dfe_pkg::RST_STOP_FIRST;
            stop_second_reg  <= dfe_pkg::RST_STOP_SECOND;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dfe_pkg::REG_START_FIRST:  start_first_reg  <= cfg_data;
                dfe_pkg::REG_START_SECOND: start_second_reg <= cfg_data;
                dfe_pkg::REG_STOP_FIRST:   stop_first_reg   <= cfg_data;
                dfe_pkg::REG_STOP_SECOND:  stop_second_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            inside_reg     <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            emit_reg       <= 1'b0;
            len_reg        <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            inside_reg     <= inside_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            emit_reg       <= emit_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_pos_reg, out_byte_reg};
    assign m_tlast   = out_last_reg;

endmodule

// ===== src/dfe_checker.sv =====
module dfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed under stall");

    // input is held off until the frame's last beat is out
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during frame emission");

    // beats of a frame follow back to back with rising position
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
        m_tvalid && (m_tdata[13:8] == 6'($past(m_tdata[13:8]) + 6'd1)))
        else $error("frame position did not advance");

    // a beat right after the end of a frame opens a new frame
    a_new_frame_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[13:8] == 6'd0))
        else $error("frame after end of frame does not start at position zero");

endmodule

bind delimited_frame_extractor_core dfe_checker u_dfe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/frame_checker.sv =====
// Watches the byte stream, register writes and frame output of the extractor.
// Predicts the frame beats each accepted byte causes and compares them in order.
module frame_checker
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,     // [7:0] frame_byte, [13:8] byte_position, [15:14] 0
    input  logic        m_tlast,     // last_in_frame
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  position;
        logic              last;
    } frame_beat_t;

    frame_beat_t frame_beats_due[$];

    logic [BYTE_W-1:0] start_a;
    logic [BYTE_W-1:0] start_b;
    logic [BYTE_W-1:0] stop_a;
    logic [BYTE_W-1:0] stop_b;

    logic [BYTE_W-1:0] held_bytes [MAX_FRAME];
    int                held_count;
    logic              in_frame;
    logic [BYTE_W-1:0] prev_byte;
    logic              prev_ok;
    int                mismatches;

    task automatic hunt_start(input logic [BYTE_W-1:0] b);
        if (prev_ok && prev_byte == start_a && b == start_b) begin
            held_bytes[0] = start_a;
            held_bytes[1] = start_b;
            held_count    = DELIM_LEN;
            in_frame      = 1'b1;
            prev_ok       = 1'b0;
        end
        else begin
            prev_byte = b;
            prev_ok   = 1'b1;
        end
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        frame_beat_t beat;
        if (!in_frame) begin
            hunt_start(b);
        end
        else if (held_count >= MAX_FRAME) begin
            // store full: drop the frame, byte goes back to the start hunt
            in_frame   = 1'b0;
            held_count = 0;
            hunt_start(b);
        end
        else begin
            held_bytes[held_count] = b;
            held_count++;
            if (prev_ok && prev_byte == stop_a && b == stop_b) begin
                for (int i = 0; i < held_count; i++) begin
                    beat.frame_byte = held_bytes[i];
                    beat.position   = POS_W'(i);
                    beat.last       = (i + 1 == held_count);
                    frame_beats_due.push_back(beat);
                end
                in_frame   = 1'b0;
                held_count = 0;
                prev_ok    = 1'b0;
            end
            else begin
                prev_byte = b;
                prev_ok   = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (!rst_n) begin
            start_a    = RST_START_FIRST;
            start_b    = RST_START_SECOND;
            stop_a     = RST_STOP_FIRST;
            stop_b     = RST_STOP_SECOND;
            held_count = 0;
            in_frame   = 1'b0;
            prev_byte  = '0;
            prev_ok    = 1'b0;
            mismatches = 0;
            frame_beats_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else begin
            // output first: a beat never belongs to a byte taken at the same edge
            if (m_tvalid && m_tready) begin
                got.frame_byte = m_tdata[7:0];
                got.position   = m_tdata[13:8];
                got.last       = m_tlast;
                if (frame_beats_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected frame beat: byte %h pos %0d last %b",
                                 got.frame_byte, got.position, got.last);
                    mismatches++;
                end
                else begin
                    want = frame_beats_due.pop_front();
                    if (got != want || m_tdata[15:14] != 2'b00) begin
                        if (mismatches < 10)
                            $display({"frame beat mismatch: expected byte %h pos %0d last %b,",
                                      " got byte %h pos %0d last %b pad %b"},
                                     want.frame_byte, want.position, want.last,
                                     got.frame_byte, got.position, got.last,
                                     m_tdata[15:14]);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_FIRST:  start_a = cfg_data;
                    REG_START_SECOND: start_b = cfg_data;
                    REG_STOP_FIRST:   stop_a  = cfg_data;
                    REG_STOP_SECOND:  stop_b  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);
            errors  <= mismatches;
            pending <= frame_beats_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int MAX_FRAME     = 32;
    localparam int SETTLE_CYCLES = MAX_FRAME + 16;

    // indexes with no register behind them
    localparam logic [dfe_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [dfe_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    typedef enum int {
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_OVERFLOW,
        FRAME_BROKEN,
        FRAME_NOISE
    } frame_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    int errors;
    int pending;

    bit calm = 1'b0;
    int bytes_sent = 0;

    // delimiters currently programmed, used to shape the stream
    logic [7:0] sf = dfe_pkg::RST_START_FIRST;
    logic [7:0] ss = dfe_pkg::RST_START_SECOND;
    logic [7:0] pf = dfe_pkg::RST_STOP_FIRST;
    logic [7:0] ps = dfe_pkg::RST_STOP_SECOND;

    delimited_frame_extractor_core #(.MAX_FRAME(MAX_FRAME)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: stall bursts, always ready once calm
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return sf;
            1:       return ss;
            2:       return pf;
            3:       return ps;
            default: return 8'($urandom);
        endcase
    endfunction

    // never equal to stop_first, so no stop pair can form inside
    function automatic logic [7:0] clean_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == pf) ? ~b : b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic wait_for_frames();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic settle();
        wait_for_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_delims(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c, input logic [7:0] d,
                                  input bit stray);
        if (stray)
            put_reg(REG_UNUSED_LO, 8'($urandom));
        put_reg(dfe_pkg::REG_START_FIRST, a);
        put_reg(dfe_pkg::REG_START_SECOND, b);
        put_reg(dfe_pkg::REG_STOP_FIRST, c);
        if (stray)
            put_reg(REG_UNUSED_HI, 8'($urandom));
        put_reg(dfe_pkg::REG_STOP_SECOND, d);
        cfg_valid <= 1'b0;
        sf = a;
        ss = b;
        pf = c;
        ps = d;
    endtask

    task automatic send_clean_payload(input int n);
        repeat (n) send_byte(clean_byte());
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] b;
        int n;
        if (kind == FRAME_NOISE)
        begin
            repeat ($urandom_range(1, 4)) send_byte(pick_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 2)) send_byte(pick_byte());
            send_byte(sf);
            send_byte(ss);
            case (kind)
                FRAME_LONG:     n = $urandom_range(7, MAX_FRAME - 4);
                FRAME_OVERFLOW: n = $urandom_range(MAX_FRAME - 3, MAX_FRAME + 1);
                default:        n = $urandom_range(0, 6);
            endcase
            repeat (n) send_byte(pick_byte());
            send_byte(pf);
            if (kind == FRAME_BROKEN)
            begin
                b = pick_byte();
                send_byte((b == ps) ? ~b : b);
            end
            else
            begin
                send_byte(ps);
            end
        end
    endtask

    task automatic run_phase(input int count);
        int target;
        int r;
        frame_kind_t kind;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            r = $urandom_range(0, 15);
            if (r < 7)       kind = FRAME_SHORT;
            else if (r < 10) kind = FRAME_LONG;
            else if (r < 11) kind = FRAME_OVERFLOW;
            else if (r < 13) kind = FRAME_BROKEN;
            else             kind = FRAME_NOISE;
            send_frame(kind);
            if (!calm && $urandom_range(0, 7) == 0)
                wait_for_frames();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset delimiters
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sf);
        send_byte(sf);
        send_byte(ss);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(pf);
        send_byte(ps);
        send_byte(ss);              // stop byte must not pair into a start
        send_byte(sf);
        send_byte(ss);
        send_byte(pf);
        send_byte(ps);              // shortest frame
        send_byte(sf);
        send_byte(ss);
        send_byte(ps);
        send_byte(pf);
        send_byte(pf);
        send_byte(ps);

        // full store, then overflow on the stop pair, then overflow into a new start
        send_byte(sf);
        send_byte(ss);
        send_clean_payload(MAX_FRAME - 4);
        send_byte(pf);
        send_byte(ps);
        send_byte(sf);
        send_byte(ss);
        send_clean_payload(MAX_FRAME - 3);
        send_byte(pf);
        send_byte(ps);
        send_byte(sf);
        send_byte(ss);
        send_clean_payload(MAX_FRAME - 3);
        send_byte(pf);
        send_byte(ss);              // stop_first equals start_first here
        send_clean_payload(3);
        send_byte(pf);
        send_byte(ps);
        wait_for_frames();

        run_phase(6);
        settle();
        program_delims(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        run_phase(6);
        settle();
        program_delims(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        run_phase(6);
        settle();
        program_delims(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
        run_phase(6);
        settle();
        begin
            logic [7:0] a;
            logic [7:0] b;
            a = 8'($urandom);
            b = 8'($urandom);
            program_delims(a, b, a, b, 1'b0);
        end
        run_phase(6);
        settle();
        program_delims(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        run_phase(6);
        settle();
        program_delims(dfe_pkg::RST_START_FIRST, dfe_pkg::RST_START_SECOND,
                       dfe_pkg::RST_STOP_FIRST, dfe_pkg::RST_STOP_SECOND, 1'b0);
        calm = 1'b1;
        run_phase(6);
        settle();

        if (pending != 0)
            $display("%0d frame beats never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
